// ----- sv/iem_pkg.sv -----
// ----------------------------------------------------------------------------
// iem_pkg: shared types and constants for the image error metrics block
// Holds the sizing constants, the per-frame sums word, the back part state
// codes and the square-root lookup table.
// ----------------------------------------------------------------------------
package iem_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int SQRT_FRAC_BITS = 16;

  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int D_W        = COUNT_BITS + 2;
  localparam int ABS_W      = COUNT_BITS + 10;
  localparam int SQ_W       = COUNT_BITS + 18;
  localparam int SQRT_W     = SQRT_FRAC_BITS + 1;
  localparam int SQRT_SUM_W = COUNT_BITS + SQRT_FRAC_BITS + 3;
  localparam int DEN_W      = D_W + ((SQRT_FRAC_BITS > 16) ? SQRT_FRAC_BITS : 16);
  localparam int NUM_W      = SQ_W + 32;
  localparam int Q_W        = 64;

  localparam logic [14:0] PSNR_CAP        = 15'd30720;
  localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;

  // Sums of one frame, handed from the front part to the back part.
  typedef struct packed {
    logic [ABS_W-1:0]      abs_sum;
    logic [SQ_W-1:0]       sq_sum;
    logic [SQRT_SUM_W-1:0] sqrt_sum;
    logic [CNT_W-1:0]      count;
    logic                  ovf;
  } frame_sums_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_ADJ,
    ST_PSNR_MUL,
    ST_PSNR_CAP,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    OP_MAE,
    OP_MSE,
    OP_SQRT,
    OP_PSNR
  } div_op_t;

  typedef logic [SQRT_W-1:0] sqrt_lut_t [256];

  // sqrt(d/255) in Q1.SQRT_FRAC_BITS, rounded to nearest with ties up.
  function automatic sqrt_lut_t build_sqrt_lut();
    sqrt_lut_t       lut;
    longint unsigned t;
    longint unsigned r;
    longint unsigned c;
    for (int d = 0; d < 256; d++) begin
      t = longint'(d) << (2 * SQRT_FRAC_BITS);
      r = 0;
      for (int b = SQRT_FRAC_BITS; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (255 * c * c <= t) begin
          r = c;
        end
      end
      if (255 * (2 * r + 1) * (2 * r + 1) <= 4 * t) begin
        r = r + 1;
      end
      lut[d] = SQRT_W'(r);
    end
    return lut;
  endfunction

  localparam sqrt_lut_t SQRT_LUT = build_sqrt_lut();

endpackage

// ----- sv/iem_front.sv -----
// ----------------------------------------------------------------------------
// iem_front: pixel accumulator
// Takes one pixel pair a cycle while the queue is not full, adds the three
// channel differences to the running sums, queues a finished frame's sums.
// ----------------------------------------------------------------------------
module iem_front import iem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_a_red,
  input  logic [7:0]  in_a_green,
  input  logic [7:0]  in_a_blue,
  input  logic [7:0]  in_b_red,
  input  logic [7:0]  in_b_green,
  input  logic [7:0]  in_b_blue,
  input  logic        in_frame_end,
  input  logic        q_full,
  output logic        q_push,
  output frame_sums_t q_data
);

  frame_sums_t sums_r, sums_nxt, acc;
  logic [7:0]  d_r, d_g, d_b;
  logic [9:0]  abs_add;
  logic [17:0] sq_add;
  logic [SQRT_W+1:0] sqrt_add;
  logic        at_cap;
  logic        accept;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    d_r      = absdiff(in_a_red, in_b_red);
    d_g      = absdiff(in_a_green, in_b_green);
    d_b      = absdiff(in_a_blue, in_b_blue);
    abs_add  = 10'(d_r) + 10'(d_g) + 10'(d_b);
    sq_add   = 18'(d_r) * 18'(d_r) + 18'(d_g) * 18'(d_g) + 18'(d_b) * 18'(d_b);
    sqrt_add = (SQRT_W+2)'(SQRT_LUT[d_r]) + (SQRT_W+2)'(SQRT_LUT[d_g])
             + (SQRT_W+2)'(SQRT_LUT[d_b]);
    at_cap   = (sums_r.count == {1'b1, {COUNT_BITS{1'b0}}});

    acc = sums_r;
    if (at_cap) begin
      acc.ovf = 1'b1;
    end else begin
      acc.abs_sum  = sums_r.abs_sum + ABS_W'(abs_add);
      acc.sq_sum   = sums_r.sq_sum + SQ_W'(sq_add);
      acc.sqrt_sum = sums_r.sqrt_sum + SQRT_SUM_W'(sqrt_add);
      acc.count    = sums_r.count + CNT_W'(1);
    end

    q_data   = acc;
    q_push   = accept && in_frame_end;
    sums_nxt = sums_r;
    if (accept) begin
      sums_nxt = in_frame_end ? '0 : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else begin
      sums_r <= sums_nxt;
    end
  end

endmodule

// ----- sv/iem_fifo.sv -----
// ----------------------------------------------------------------------------
// iem_fifo: two-entry queue of frame sums
// Lets the accumulator keep taking pixels while the back part is busy.
// ----------------------------------------------------------------------------
module iem_fifo import iem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_sums_t push_data,
  input  logic        pop,
  output frame_sums_t pop_data,
  output logic        full,
  output logic        empty
);

  frame_sums_t regs_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = regs_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      regs_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/iem_div.sv -----
// ----------------------------------------------------------------------------
// iem_div: restoring divider
// One quotient bit a cycle; the quotient keeps its low 64 bits.
// ----------------------------------------------------------------------------
module iem_div import iem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [Q_W-1:0]   q_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   r_sh;
  logic             ge;

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

  always_comb begin
    r_sh = {rem_r, num_r[NUM_W-1]};
    ge   = (r_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? DEN_W'(r_sh - {1'b0, den_r}) : DEN_W'(r_sh);
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/iem_back.sv -----
// ----------------------------------------------------------------------------
// iem_back: frame result sequencer
// Pops frame sums, runs up to four divisions on the shared divider, takes
// the log for PSNR by repeated squaring and holds the result word.
// ----------------------------------------------------------------------------
module iem_back import iem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  frame_sums_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_mean_abs_error,
  output logic [32:0] out_mean_sq_error,
  output logic [16:0] out_mean_sqrt_error,
  output logic [14:0] out_psnr_db,
  output logic [24:0] out_pixels_seen,
  output logic        out_count_overflow
);

  back_state_t state_r, state_nxt;
  div_op_t     op_r, op_nxt;
  frame_sums_t sums_r, sums_nxt;
  logic [DEN_W-1:0] den_mae_r, den_mae_nxt, den_mse_r, den_mse_nxt;
  logic [DEN_W-1:0] den_sqrt_r, den_sqrt_nxt;
  logic [16:0] mae_r, mae_nxt, sqrt_r, sqrt_nxt;
  logic [32:0] mse_r, mse_nxt;
  logic [14:0] psnr_r, psnr_nxt;
  logic [Q_W-1:0] qn_r, qn_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [30:0] y_r, y_nxt;
  logic [61:0] prod_r, prod_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [39:0] pmul_r, pmul_nxt;
  logic [31:0] t_sq;
  logic [21:0] l_val;
  logic [15:0] p_val;

  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [Q_W-1:0]   div_q;

  iem_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    unique case (op_r)
      OP_MAE: begin
        div_num = NUM_W'(sums_r.abs_sum) << 16;
        div_den = den_mae_r;
      end
      OP_MSE: begin
        div_num = NUM_W'(sums_r.sq_sum) << 32;
        div_den = den_mse_r;
      end
      OP_SQRT: begin
        div_num = NUM_W'(sums_r.sqrt_sum) << 16;
        div_den = den_sqrt_r;
      end
      default: begin
        div_num = NUM_W'(den_mse_r) << 16;
        div_den = DEN_W'(sums_r.sq_sum);
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    sums_nxt     = sums_r;
    den_mae_nxt  = den_mae_r;
    den_mse_nxt  = den_mse_r;
    den_sqrt_nxt = den_sqrt_r;
    mae_nxt      = mae_r;
    mse_nxt      = mse_r;
    sqrt_nxt     = sqrt_r;
    psnr_nxt     = psnr_r;
    qn_nxt       = qn_r;
    sh_nxt       = sh_r;
    y_nxt        = y_r;
    prod_nxt     = prod_r;
    frac_nxt     = frac_r;
    step_nxt     = step_r;
    pmul_nxt     = pmul_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    t_sq         = prod_r[61:30];
    l_val        = {6'd47 - sh_r, frac_r};
    p_val        = pmul_r[39:24];

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          sums_nxt  = q_data;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        den_mae_nxt  = DEN_W'(sums_r.count) * DEN_W'(765);
        den_mse_nxt  = DEN_W'(sums_r.count) * DEN_W'(195075);
        den_sqrt_nxt = DEN_W'(DEN_W'(sums_r.count) * DEN_W'(3)) << SQRT_FRAC_BITS;
        op_nxt       = OP_MAE;
        state_nxt    = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        if (op_r == OP_PSNR && sums_r.sq_sum == '0) begin
          psnr_nxt  = PSNR_CAP;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (op_r)
            OP_MAE: begin
              mae_nxt   = div_q[16:0];
              op_nxt    = OP_MSE;
              state_nxt = ST_DIV_GO;
            end
            OP_MSE: begin
              mse_nxt   = div_q[32:0];
              op_nxt    = OP_SQRT;
              state_nxt = ST_DIV_GO;
            end
            OP_SQRT: begin
              sqrt_nxt  = div_q[16:0];
              op_nxt    = OP_PSNR;
              state_nxt = ST_DIV_GO;
            end
            default: begin
              if (div_q[Q_W-1:16] == '0) begin
                psnr_nxt  = '0;
                state_nxt = ST_OUT;
              end else begin
                qn_nxt    = div_q;
                sh_nxt    = '0;
                state_nxt = ST_NORM;
              end
            end
          endcase
        end
      end
      ST_NORM: begin
        if (qn_r[Q_W-1]) begin
          y_nxt     = qn_r[Q_W-1:Q_W-31];
          frac_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_LOG_MUL;
        end else begin
          qn_nxt = qn_r << 1;
          sh_nxt = sh_r + 6'd1;
        end
      end
      ST_LOG_MUL: begin
        prod_nxt  = 62'(y_r) * 62'(y_r);
        state_nxt = ST_LOG_ADJ;
      end
      ST_LOG_ADJ: begin
        if (t_sq[31]) begin
          y_nxt    = t_sq[31:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          y_nxt    = t_sq[30:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        if (step_r == 4'd15) begin
          state_nxt = ST_PSNR_MUL;
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = ST_LOG_MUL;
        end
      end
      ST_PSNR_MUL: begin
        pmul_nxt  = 40'(l_val) * 40'(TEN_LOG10_2_Q16);
        state_nxt = ST_PSNR_CAP;
      end
      ST_PSNR_CAP: begin
        psnr_nxt  = (p_val > 16'(PSNR_CAP)) ? PSNR_CAP : p_val[14:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_MAE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sums_r     <= sums_nxt;
    den_mae_r  <= den_mae_nxt;
    den_mse_r  <= den_mse_nxt;
    den_sqrt_r <= den_sqrt_nxt;
    mae_r      <= mae_nxt;
    mse_r      <= mse_nxt;
    sqrt_r     <= sqrt_nxt;
    psnr_r     <= psnr_nxt;
    qn_r       <= qn_nxt;
    sh_r       <= sh_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    frac_r     <= frac_nxt;
    step_r     <= step_nxt;
    pmul_r     <= pmul_nxt;
  end

  assign out_valid           = (state_r == ST_OUT);
  assign out_mean_abs_error  = mae_r;
  assign out_mean_sq_error   = mse_r;
  assign out_mean_sqrt_error = sqrt_r;
  assign out_psnr_db         = psnr_r;
  assign out_pixels_seen     = 25'(sums_r.count);
  assign out_count_overflow  = sums_r.ovf;

  a_psnr_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_psnr_db <= PSNR_CAP)
    else $error("PSNR above cap");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixels_seen != '0)
    else $error("result for an empty frame");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_mae_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mean_abs_error <= 17'h10000)
    else $error("MAE out of range");

endmodule

// ----- sv/image_error_metrics.sv -----
// ----------------------------------------------------------------------------
// image_error_metrics: streaming MAE / MSE / sqrt-error / PSNR of an image pair
// Accumulates per-frame error sums and reports the frame metrics.
// ----------------------------------------------------------------------------
// Each input word is one pixel pair (RGB bytes of image A and image B). The
// accumulator takes one word every clock cycle; it only stops taking words
// while the two-entry frame queue is full. A word with frame_end set closes
// the frame: its sums go into the queue and the running sums clear at once,
// so the next frame can start in the following cycle. The result sequencer
// then works on one frame at a time: a setup state, up to four restoring
// divisions on one shared divider of NUM_W (74) bits, a leading-zero shift
// of up to 47 bit positions, repeated squaring for the 16 log bits, and a
// multiply and cap for the dB scale. The result word waits in the output
// register until it is taken. Frames much shorter than one sequencer pass
// backlog into the queue and then stall the input. The pixel counter
// saturates at 2^COUNT_BITS; further pixels of the frame are dropped and
// count_overflow is set in that frame's result.
// ----------------------------------------------------------------------------
module image_error_metrics import iem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_a_red,
  input  logic [7:0]  in_a_green,
  input  logic [7:0]  in_a_blue,
  input  logic [7:0]  in_b_red,
  input  logic [7:0]  in_b_green,
  input  logic [7:0]  in_b_blue,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_mean_abs_error,
  output logic [32:0] out_mean_sq_error,
  output logic [16:0] out_mean_sqrt_error,
  output logic [14:0] out_psnr_db,
  output logic [24:0] out_pixels_seen,
  output logic        out_count_overflow
);

  // Handoff between the accumulator and the result sequencer.
  logic        q_push, q_pop, q_full, q_empty;
  frame_sums_t q_in, q_out;

  iem_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_red     (in_a_red),
    .in_a_green   (in_a_green),
    .in_a_blue    (in_a_blue),
    .in_b_red     (in_b_red),
    .in_b_green   (in_b_green),
    .in_b_blue    (in_b_blue),
    .in_frame_end (in_frame_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  iem_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  iem_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_data              (q_out),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mean_abs_error  (out_mean_abs_error),
    .out_mean_sq_error   (out_mean_sq_error),
    .out_mean_sqrt_error (out_mean_sqrt_error),
    .out_psnr_db         (out_psnr_db),
    .out_pixels_seen     (out_pixels_seen),
    .out_count_overflow  (out_count_overflow)
  );

endmodule

// ----- dv/tb_image_error_metrics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_error_metrics: self-checking bench for the image error metrics block
// A directed table of pixel pairs, then random frames, drives the pixel port.
// Each frame result is compared field by field with a typed row or a local error model.
// ----------------------------------------------------------------------------
module tb_image_error_metrics;

  // The bench keeps its own copy of the frame sums. Every accepted pixel word
  // updates them, and a word with frame_end set turns them into one expected
  // metrics word, which is queued until the block hands out its result.
  localparam int TOTAL_PIXELS = 650;
  localparam int SETTLE_CYCLES = 600;  // more than one full back-part pass

  typedef struct {
    logic [16:0] mae;
    logic [32:0] mse;
    logic [16:0] msqrt;
    logic [14:0] psnr;
    logic [24:0] npix;
    logic        ovf;
  } metrics_t;

  typedef struct {
    logic [7:0] ar, ag, ab, br, bg, bb;
    logic       fe;
    bit         typed;   // expected result given in the row itself
    metrics_t   res;
  } pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_a_red, in_a_green, in_a_blue;
  logic [7:0]  in_b_red, in_b_green, in_b_blue;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] out_mean_abs_error;
  logic [32:0] out_mean_sq_error;
  logic [16:0] out_mean_sqrt_error;
  logic [14:0] out_psnr_db;
  logic [24:0] out_pixels_seen;
  logic        out_count_overflow;

  image_error_metrics dut (.*);

  // Frame sums of the model, cleared when each frame closes.
  logic [63:0] run_pixels, run_abs, run_sq, run_sqrt;
  logic        run_ovf;
  logic [16:0] sqrt_rom [256];

  metrics_t    pending_results[$];
  metrics_t    typed_results[$];  // typed expectation for the next closed frame
  int          mismatches = 0;
  int          frames_done = 0;
  int          pixels_sent = 0;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Builds sqrt(d/255) in Q1.16, rounded to nearest with ties going up.
  initial begin
    logic [63:0] tgt, root, trial;
    for (int d = 0; d < 256; d++) begin
      tgt = 64'(d) << 32;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (255 * trial * trial <= tgt) begin
          root = trial;
        end
      end
      if (255 * (2 * root + 1) * (2 * root + 1) <= 4 * tgt) begin
        root = root + 1;
      end
      sqrt_rom[d] = root[16:0];
    end
  end

  // floor(num * 2^shift / den) with enough headroom for every metric.
  function automatic logic [127:0] scaled_quotient(logic [63:0] num, int shift,
                                                   logic [63:0] den);
    logic [127:0] wide;
    wide = 128'(num) << shift;
    return wide / 128'(den);
  endfunction

  // PSNR in Q7.8: fixed-point log2 of the peak-to-error ratio by repeated
  // squaring of a normalized mantissa, then scaled by 10*log10(2).
  function automatic logic [14:0] psnr_from_sums(logic [63:0] peak, logic [63:0] sq);
    logic [63:0]  ratio, mant, frac, log2v, db;
    logic [127:0] prod;
    int           top;
    if (sq == 0) begin
      return 15'd30720;
    end
    ratio = 64'(scaled_quotient(peak, 16, sq));
    if (ratio < 64'd65536) begin
      return 15'd0;
    end
    top = 63;
    while (ratio[top] == 1'b0) begin
      top--;
    end
    mant = (top >= 30) ? (ratio >> (top - 30)) : (ratio << (30 - top));
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      prod = 128'(mant) * 128'(mant);
      mant = prod[93:30];
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    log2v = (64'(top - 16) << 16) + frac;
    db = (log2v * 64'd197283) >> 24;
    return (db > 64'd30720) ? 15'd30720 : db[14:0];
  endfunction

  // Adds one pixel pair to the frame sums; returns 1 and the metrics when the
  // word closes the frame.
  function automatic bit add_pixel(logic [7:0] a [3], logic [7:0] b [3], logic fe,
                                   output metrics_t res);
    logic [63:0] d, den;
    res = '{default: '0};
    if (run_pixels >= (64'd1 << 24)) begin
      run_ovf = 1'b1;
    end else begin
      for (int c = 0; c < 3; c++) begin
        d = (a[c] >= b[c]) ? 64'(a[c] - b[c]) : 64'(b[c] - a[c]);
        run_abs += d;
        run_sq += d * d;
        run_sqrt += 64'(sqrt_rom[d[7:0]]);
      end
      run_pixels++;
    end
    if (!fe) begin
      return 1'b0;
    end
    den = 3 * run_pixels;
    res.mae = 17'(scaled_quotient(run_abs, 16, 255 * den));
    res.mse = 33'(scaled_quotient(run_sq, 32, 65025 * den));
    res.msqrt = 17'(scaled_quotient(run_sqrt, 16, den << 16));
    res.psnr = psnr_from_sums(65025 * den, run_sq);
    res.npix = run_pixels[24:0];
    res.ovf = run_ovf;
    run_pixels = 0;
    run_abs = 0;
    run_sq = 0;
    run_sqrt = 0;
    run_ovf = 0;
    return 1'b1;
  endfunction

  // Pixel side: every accepted word goes through the model. Input values are
  // read in the active region of the edge, so they are the pre-edge values.
  always @(posedge clk) begin
    logic [7:0] a [3];
    logic [7:0] b [3];
    metrics_t   res;
    if (!rst_n) begin
      run_pixels = 0;
      run_abs = 0;
      run_sq = 0;
      run_sqrt = 0;
      run_ovf = 0;
    end else if (in_valid && in_ready) begin
      a = '{in_a_red, in_a_green, in_a_blue};
      b = '{in_b_red, in_b_green, in_b_blue};
      if (add_pixel(a, b, in_frame_end, res)) begin
        if (typed_results.size() > 0) begin
          res = typed_results.pop_front();
        end
        pending_results.push_back(res);
      end
    end
  end

  task automatic compare_field(string fname, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("frame %0d: %s expected %0d, got %0d", frames_done, fname, exp_v, got_v);
      end
    end
  endtask

  // Result side: compare each metrics word with the oldest expectation.
  always @(posedge clk) begin
    metrics_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("metrics word with no frame outstanding");
        end
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("mean_abs_error", 64'(exp_r.mae), 64'(out_mean_abs_error));
        compare_field("mean_sq_error", 64'(exp_r.mse), 64'(out_mean_sq_error));
        compare_field("mean_sqrt_error", 64'(exp_r.msqrt), 64'(out_mean_sqrt_error));
        compare_field("psnr_db", 64'(exp_r.psnr), 64'(out_psnr_db));
        compare_field("pixels_seen", 64'(exp_r.npix), 64'(out_pixels_seen));
        compare_field("count_overflow", 64'(exp_r.ovf), 64'(out_count_overflow));
      end
      frames_done++;
    end
  end

  // Receiver stalls: phases of always-ready alternate with random backpressure,
  // mostly short holds and now and then a long one.
  always @(posedge clk) begin
    int mode_left;
    bit busy_mode;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        busy_mode = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (!busy_mode) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Presents one pixel word, after an optional idle gap, and holds it until
  // it is accepted.
  task automatic send_pixel(logic [7:0] a [3], logic [7:0] b [3], logic fe, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_a_red     <= a[0];
    in_a_green   <= a[1];
    in_a_blue    <= a[2];
    in_b_red     <= b[0];
    in_b_green   <= b[1];
    in_b_blue    <= b[2];
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // One edge first, so that the expectation of the word just accepted is
  // already queued when the loop looks at the queue.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Directed rows: single-pixel frames at the extremes have results that can
  // be read off directly; the mixed frames after them go through the model.
  localparam metrics_t PERFECT = '{17'd0, 33'd0, 17'd0, 15'd30720, 25'd1, 1'b0};
  localparam metrics_t WORST   = '{17'd65536, 33'h1_0000_0000, 17'd65536, 15'd0,
                                   25'd1, 1'b0};
  pixel_row_t directed_rows [] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, PERFECT},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, PERFECT},
    '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, WORST},
    '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, WORST},
    '{8'hAA, 8'h55, 8'h0F, 8'h55, 8'hAA, 8'hF0, 1'b1, 1'b0, PERFECT},
    '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, PERFECT},
    '{8'h80, 8'h7F, 8'h40, 8'h7F, 8'h80, 8'h41, 1'b0, 1'b0, PERFECT},
    '{8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, PERFECT},
    '{8'hFE, 8'h01, 8'h80, 8'h01, 8'hFE, 8'h00, 1'b0, 1'b0, PERFECT},
    '{8'h33, 8'hCC, 8'h99, 8'h66, 8'h22, 8'hDD, 1'b1, 1'b0, PERFECT},
    '{8'h10, 8'h20, 8'h30, 8'h10, 8'h20, 8'h31, 1'b0, 1'b0, PERFECT},
    '{8'h10, 8'h20, 8'h30, 8'h10, 8'h20, 8'h30, 1'b1, 1'b0, PERFECT}
  };

  initial begin
    logic [7:0] a [3];
    logic [7:0] b [3];
    int         flen, style, span;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_a_red     <= '0;
    in_a_green   <= '0;
    in_a_blue    <= '0;
    in_b_red     <= '0;
    in_b_green   <= '0;
    in_b_blue    <= '0;
    in_frame_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        typed_results.push_back(directed_rows[i].res);
      end
      a = '{directed_rows[i].ar, directed_rows[i].ag, directed_rows[i].ab};
      b = '{directed_rows[i].br, directed_rows[i].bg, directed_rows[i].bb};
      send_pixel(a, b, directed_rows[i].fe, pick_gap());
    end

    // The sender holds off once until every frame result is back.
    in_valid <= 1'b0;
    wait_drained();

    // Random frames: most are short, a few are long, so the frame queue both
    // drains and backs up. Content styles give PSNR values across the range.
    while (pixels_sent < TOTAL_PIXELS) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      style = $urandom_range(0, 3);
      for (int p = 0; p < flen; p++) begin
        for (int c = 0; c < 3; c++) begin
          a[c] = 8'($urandom_range(0, 255));
          case (style)
            0: b[c] = 8'($urandom_range(0, 255));
            1: b[c] = a[c];
            2: begin
              span = $urandom_range(0, 3);
              b[c] = ($urandom_range(0, 1) != 0) ? a[c] + 8'(span) : a[c] - 8'(span);
            end
            default: b[c] = ~a[c];
          endcase
        end
        send_pixel(a, b, (p == flen - 1), pick_gap());
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pixel words; %0d frame results checked, extremes and random.",
             pixels_sent, frames_done);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of single-pixel frames with
  // long stalls on both sides.
  initial begin
    #20ms;
    $display("watchdog expired");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- image_error_metrics.f -----
sv/iem_pkg.sv
sv/iem_front.sv
sv/iem_fifo.sv
sv/iem_div.sv
sv/iem_back.sv
sv/image_error_metrics.sv
dv/tb_image_error_metrics.sv
